// File: hw/rtl/rational_boxcar_decimator_top_macros.svh
// Assertion macros used by the top level of the rational boxcar decimator RTL.
`ifndef RATIONAL_BOXCAR_DECIMATOR_TOP_MACROS_SVH
`define RATIONAL_BOXCAR_DECIMATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define RBD_ASSERT_IMPL(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RBD_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`else

`define RBD_ASSERT_IMPL(lbl, ant, cons, msg)
`define RBD_ASSERT_NEXT(lbl, ant, cons, msg)

`endif

`endif

// File: hw/rtl/rbd_pkg.sv
// Shared types, constants and helper functions of the rational boxcar decimator.
`default_nettype none

package rbd_pkg;

    // Field and datapath widths
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int SAMPLE_FIELD_W   = 16;
    localparam int CFG_W            = 16;
    localparam int CFG_ADDR_W       = 2;
    localparam int SUM_W            = 32;
    localparam int DVS_W            = 32;
    localparam int DVD_W            = SUM_W + CFG_W;
    localparam int CNT_W            = $clog2(DVD_W + 1);

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_INTEGER_RATIO    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAC_NUMERATOR   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAC_DENOMINATOR = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] RATIO_RST = 16'd1;
    localparam logic [CFG_W-1:0] NUM_RST   = 16'd0;
    localparam logic [CFG_W-1:0] DEN_RST   = 16'd1;

    // Which product feeds the shared divider
    typedef enum logic [1:0] {
        MUL_HEAD,
        MUL_TAIL,
        MUL_MEAN
    } mul_sel_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_HEAD_START,
        ST_HEAD_DIV,
        ST_HEAD_ACC,
        ST_MEAN_START,
        ST_MEAN_DIV,
        ST_EMIT,
        ST_TAIL_START,
        ST_TAIL_DIV,
        ST_TAIL_SET
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     load_sample;
        logic     add_sample;
        logic     div_start;
        mul_sel_t mul_sel;
        logic     sum_add_q;
        logic     out_load;
        logic     close_plain;
        logic     close_split;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic boundary;
        logic close_next;
        logic div_busy;
        logic out_free;
    } dp_stat_t;

    // Zero ratio acts as one
    function automatic logic [CFG_W-1:0] eff_rate(input logic [CFG_W-1:0] r);
        return (r == '0) ? CFG_W'(1) : r;
    endfunction

    // Zero denominator acts as one
    function automatic logic [CFG_W-1:0] eff_den(input logic [CFG_W-1:0] d);
        return (d == '0) ? CFG_W'(1) : d;
    endfunction

    // Numerator clamped below the denominator
    function automatic logic [CFG_W-1:0] eff_num(input logic [CFG_W-1:0] n,
                                                 input logic [CFG_W-1:0] d);
        logic [CFG_W-1:0] de;
        de = eff_den(d);
        return (n >= de) ? (de - CFG_W'(1)) : n;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rational_boxcar_decimator_top.sv
// Top level of the rational boxcar decimator: controller, datapath and checks.
//
// Sums unsigned audio samples over windows of R + N/D samples and emits one
// result per closed window: the raw 32-bit sum and the sum scaled by D/(R*D+N).
// Slave stream s_*: one sample per transaction. Master stream m_*: one result
// per transaction. Configuration: cfg_we/cfg_addr/cfg_wdata, written while idle;
// a write to a mapped index restarts the window state and keeps the other registers.
// A sample that does not close a window needs no division; a window closed by a
// whole sample adds the scaled mean on the shared bit-serial divider, and a split
// boundary sample adds two more divisions by D for the split shares.
// A result sits in an output register; the next sample is taken while it
// waits, and only a following result stalls until m_tready frees the register.
// Reset (rst_n low, asynchronous) restores R=1, N=0, D=1, empties the window
// and drops m_tvalid.
`default_nettype none

module rational_boxcar_decimator_top
    import rbd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // sample stream
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [SAMPLE_FIELD_W-1:0] s_tdata,   // [15:0] sample
    // result stream
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [2*SUM_W-1:0]             m_tdata,   // [31:0] window_sum, [63:32] scaled_mean
    // configuration writes
    input  wire logic                      cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [CFG_W-1:0]          cfg_wdata
);

`include "rational_boxcar_decimator_top_macros.svh"

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rbd_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rbd_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .sample_in (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Checks
    `RBD_ASSERT_IMPL(a_busy_blocks_input, stat.div_busy, !s_tready, "sample taken while dividing")
    `RBD_ASSERT_IMPL(a_load_into_free_buf, cmd.out_load, stat.out_free, "result buffer overwritten")
    `RBD_ASSERT_NEXT(a_one_sample_at_a_time, s_tvalid && s_tready, !s_tready, "back-to-back accept")

endmodule

`default_nettype wire

// File: hw/rtl/rbd_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module rbd_divider
    import rbd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,   // left aligned to the iteration count
    input  wire logic [DVS_W-1:0] divisor,
    input  wire logic [CNT_W-1:0] iters,
    output logic                  busy,
    output logic [SUM_W-1:0]      quotient
);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           ge;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, q_reg[DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});

        rem_next = rem_reg;
        q_next   = q_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = '0;
            q_next   = dividend;
            dvs_next = divisor;
            cnt_next = iters;
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            q_next   = {q_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // Operand registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = q_reg[SUM_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/rbd_datapath.sv
// Datapath: configuration registers, window state, multipliers, divider, result buffer.
`default_nettype none

module rbd_datapath
    import rbd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [CFG_W-1:0]          cfg_wdata,
    input  wire logic [SAMPLE_FIELD_W-1:0] sample_in,
    input  wire dp_cmd_t                   cmd,
    output dp_stat_t                       stat,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [2*SUM_W-1:0]             m_tdata
);

    // Sample bits that are kept; the field itself is SAMPLE_FIELD_W wide
    localparam int SW_EFF = (SAMPLE_WIDTH < SAMPLE_FIELD_W) ? SAMPLE_WIDTH : SAMPLE_FIELD_W;
    localparam int PROD_W = SW_EFF + CFG_W;
    localparam int SHORT_SHIFT = DVD_W - PROD_W;
    localparam logic [CNT_W-1:0] SHORT_ITERS = CNT_W'(PROD_W);
    localparam logic [CNT_W-1:0] LONG_ITERS  = CNT_W'(DVD_W);

    logic [CFG_W-1:0] ratio_reg, ratio_next;
    logic [CFG_W-1:0] num_reg, num_next;
    logic [CFG_W-1:0] den_reg, den_next;
    logic             cfg_hit;
    logic [DVS_W-1:0] rdiv_reg, rdiv_next;

    logic [SW_EFF-1:0] sample_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CFG_W-1:0]  phase_reg, phase_next;
    logic [CFG_W-1:0]  fl_reg, fl_next;

    logic [CFG_W-1:0] rate_eff, num_eff, den_eff, nfl;
    logic [CFG_W-1:0] share;
    logic [PROD_W-1:0] short_prod;
    logic [DVD_W-1:0]  mean_prod;
    logic [DVD_W-1:0]  dvd;
    logic [DVS_W-1:0]  dvs;
    logic [CNT_W-1:0]  iters;
    logic              div_busy;
    logic [SUM_W-1:0]  quotient;

    logic [SUM_W-1:0] ws_reg, sm_reg;
    logic             mv_reg, mv_next;
    logic             out_free;

    // Register writes
    always_comb
    begin
        ratio_next = ratio_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        cfg_hit    = 1'b0;
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_INTEGER_RATIO:
                begin
                    ratio_next = cfg_wdata;
                    cfg_hit    = 1'b1;
                end
                CFG_FRAC_NUMERATOR:
                begin
                    num_next = cfg_wdata;
                    cfg_hit  = 1'b1;
                end
                CFG_FRAC_DENOMINATOR:
                begin
                    den_next = cfg_wdata;
                    cfg_hit  = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
        // Full divisor R*D + N, kept in step with the registers
        rdiv_next = DVS_W'(eff_rate(ratio_next)) * DVS_W'(eff_den(den_next))
                  + DVS_W'(eff_num(num_next, den_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= RATIO_RST;
            num_reg   <= NUM_RST;
            den_reg   <= DEN_RST;
            rdiv_reg  <= DVS_W'(eff_rate(RATIO_RST)) * DVS_W'(eff_den(DEN_RST))
                       + DVS_W'(eff_num(NUM_RST, DEN_RST));
        end
        else
        begin
            ratio_reg <= ratio_next;
            num_reg   <= num_next;
            den_reg   <= den_next;
            rdiv_reg  <= rdiv_next;
        end
    end

    assign rate_eff = eff_rate(ratio_reg);
    assign den_eff  = eff_den(den_reg);
    assign num_eff  = eff_num(num_reg, den_reg);
    assign nfl      = den_eff - fl_reg;

    // Products into the divider; the short ones are left aligned
    always_comb
    begin
        share      = (cmd.mul_sel == MUL_HEAD) ? fl_reg : nfl;
        short_prod = PROD_W'(sample_reg) * PROD_W'(share);
        mean_prod  = DVD_W'(sum_reg) * DVD_W'(den_eff);
        if (cmd.mul_sel == MUL_MEAN)
        begin
            dvd   = mean_prod;
            dvs   = rdiv_reg;
            iters = LONG_ITERS;
        end
        else
        begin
            dvd   = DVD_W'(short_prod) << SHORT_SHIFT;
            dvs   = DVS_W'(den_eff);
            iters = SHORT_ITERS;
        end
    end

    rbd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .iters    (iters),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Input sample capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
            sample_reg <= sample_in[SW_EFF-1:0];
    end

    // Window state update
    always_comb
    begin
        sum_next   = sum_reg;
        phase_next = phase_reg;
        fl_next    = fl_reg;
        if (cfg_hit)
        begin
            sum_next   = '0;
            phase_next = '0;
            fl_next    = eff_num(num_next, den_next);
        end
        else if (cmd.add_sample)
        begin
            sum_next   = sum_reg + SUM_W'(sample_reg);
            phase_next = phase_reg + CFG_W'(1);
        end
        else if (cmd.sum_add_q)
        begin
            sum_next = sum_reg + quotient;
        end
        else if (cmd.close_plain)
        begin
            sum_next   = '0;
            phase_next = '0;
            fl_next    = num_eff;
        end
        else if (cmd.close_split)
        begin
            sum_next = quotient;
            if (nfl > num_eff)
            begin
                phase_next = CFG_W'(1);
                fl_next    = num_eff + fl_reg;
            end
            else
            begin
                phase_next = '0;
                fl_next    = num_eff - nfl;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            phase_reg <= '0;
            fl_reg    <= eff_num(NUM_RST, DEN_RST);
        end
        else
        begin
            sum_reg   <= sum_next;
            phase_reg <= phase_next;
            fl_reg    <= fl_next;
        end
    end

    // Result buffer
    assign out_free = !mv_reg || m_tready;

    always_comb
    begin
        mv_next = mv_reg;
        if (cmd.out_load)
            mv_next = 1'b1;
        else if (m_tready)
            mv_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mv_reg <= 1'b0;
        else
            mv_reg <= mv_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            ws_reg <= sum_reg;
            sm_reg <= quotient;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {sm_reg, ws_reg};

    // Status to the controller
    always_comb
    begin
        stat.boundary   = (phase_reg >= rate_eff);
        stat.close_next = (({1'b0, phase_reg} + 17'd1) >= {1'b0, rate_eff})
                        && (fl_reg == '0);
        stat.div_busy   = div_busy;
        stat.out_free   = out_free;
    end

endmodule

`default_nettype wire

// File: hw/rtl/rbd_controller.sv
// Controller state machine sequencing one sample transaction at a time.
`default_nettype none

module rbd_controller
    import rbd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    ctrl_state_t state_reg, state_next;
    logic        split_reg, split_next;

    // State and split flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            split_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            split_reg <= split_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        split_next  = split_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_HEAD;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_sample = 1'b1;
                    split_next      = stat.boundary;
                    state_next      = stat.boundary ? ST_HEAD_START : ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.add_sample = 1'b1;
                state_next     = stat.close_next ? ST_MEAN_START : ST_IDLE;
            end
            // boundary sample: share owed to the closing window
            ST_HEAD_START:
            begin
                cmd.div_start = 1'b1;
                cmd.mul_sel   = MUL_HEAD;
                state_next    = ST_HEAD_DIV;
            end
            ST_HEAD_DIV:
            begin
                if (!stat.div_busy)
                    state_next = ST_HEAD_ACC;
            end
            ST_HEAD_ACC:
            begin
                cmd.sum_add_q = 1'b1;
                state_next    = ST_MEAN_START;
            end
            // scaled mean of the closed window
            ST_MEAN_START:
            begin
                cmd.div_start = 1'b1;
                cmd.mul_sel   = MUL_MEAN;
                state_next    = ST_MEAN_DIV;
            end
            ST_MEAN_DIV:
            begin
                cmd.mul_sel = MUL_MEAN;
                if (!stat.div_busy)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (split_reg)
                    begin
                        state_next = ST_TAIL_START;
                    end
                    else
                    begin
                        cmd.close_plain = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            // remainder of the boundary sample opens the next window
            ST_TAIL_START:
            begin
                cmd.div_start = 1'b1;
                cmd.mul_sel   = MUL_TAIL;
                state_next    = ST_TAIL_DIV;
            end
            ST_TAIL_DIV:
            begin
                cmd.mul_sel = MUL_TAIL;
                if (!stat.div_busy)
                    state_next = ST_TAIL_SET;
            end
            ST_TAIL_SET:
            begin
                cmd.mul_sel     = MUL_TAIL;
                cmd.close_split = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: test/rbd_window_checker.sv
// Checker for the rational boxcar decimator: watches all channels, predicts and compares results.
`timescale 1ns / 1ps

module rbd_window_checker
    import rbd_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    input  wire logic                      s_tready,
    input  wire logic [SAMPLE_FIELD_W-1:0] s_tdata,   // [15:0] sample
    input  wire logic                      m_tvalid,
    input  wire logic                      m_tready,
    input  wire logic [2*SUM_W-1:0]        m_tdata,   // [31:0] window_sum, [63:32] scaled_mean
    input  wire logic                      cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [CFG_W-1:0]          cfg_wdata,
    output int                             fail_count,
    output int                             pending,
    output int                             windows_seen
);

    typedef struct {
        logic [SUM_W-1:0] window_sum;
        logic [SUM_W-1:0] scaled_mean;
    } window_result_t;

    // Shadow copy of the ratio registers
    logic [CFG_W-1:0] ratio_reg;
    logic [CFG_W-1:0] num_reg;
    logic [CFG_W-1:0] den_reg;

    // Shadow copy of the open window
    logic [SUM_W-1:0] open_sum;
    logic [CFG_W-1:0] whole_count;
    logic [CFG_W-1:0] owed_share;

    // Windows predicted but not yet seen on the result stream
    window_result_t window_q[$];

    function automatic logic [CFG_W-1:0] ratio_in_use();
        return (ratio_reg == '0) ? CFG_W'(1) : ratio_reg;
    endfunction

    function automatic logic [CFG_W-1:0] denom_in_use();
        return (den_reg == '0) ? CFG_W'(1) : den_reg;
    endfunction

    // Numerator at or above the denominator is clamped to D-1
    function automatic logic [CFG_W-1:0] numer_in_use();
        logic [CFG_W-1:0] d;
        d = denom_in_use();
        return (num_reg >= d) ? d - CFG_W'(1) : num_reg;
    endfunction

    task automatic restart_window();
        open_sum    = '0;
        whole_count = '0;
        owed_share  = numer_in_use();
    endtask

    // Close the open window: raw sum and sum scaled by D/(R*D+N)
    task automatic close_window();
        window_result_t r;
        logic [63:0]    divisor;
        divisor       = 64'(ratio_in_use()) * 64'(denom_in_use()) + 64'(numer_in_use());
        r.window_sum  = open_sum;
        r.scaled_mean = SUM_W'((64'(open_sum) * 64'(denom_in_use())) / divisor);
        window_q.push_back(r);
    endtask

    // Advance the window by one accepted sample
    task automatic take_sample(input logic [SAMPLE_FIELD_W-1:0] smp);
        logic [63:0]      s;
        logic [CFG_W-1:0] rate;
        logic [CFG_W-1:0] n;
        logic [CFG_W-1:0] d;
        logic [CFG_W-1:0] opening;
        s    = 64'(smp);   // sample width equals the field width here
        rate = ratio_in_use();
        n    = numer_in_use();
        d    = denom_in_use();
        if (whole_count < rate)
        begin
            open_sum    = open_sum + SUM_W'(s);
            whole_count = whole_count + CFG_W'(1);
            if (whole_count >= rate && owed_share == '0)
            begin
                close_window();
                restart_window();
            end
        end
        else
        begin
            // boundary sample: owed share closes, remainder opens the next window
            opening  = d - owed_share;
            open_sum = open_sum + SUM_W'((s * 64'(owed_share)) / 64'(d));
            close_window();
            open_sum = SUM_W'((s * 64'(opening)) / 64'(d));
            if (opening > n)
            begin
                whole_count = CFG_W'(1);
                owed_share  = n + d - opening;
            end
            else
            begin
                whole_count = '0;
                owed_share  = n - opening;
            end
        end
    endtask

    // Monitor: results first, then register writes, then samples
    always @(posedge clk or negedge rst_n)
    begin
        window_result_t want;
        if (!rst_n)
        begin
            ratio_reg    = RATIO_RST;
            num_reg      = NUM_RST;
            den_reg      = DEN_RST;
            restart_window();
            window_q.delete();
            fail_count   = 0;
            windows_seen = 0;
            pending      = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                windows_seen++;
                if (window_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result transaction sum=%h mean=%h",
                             $time, m_tdata[SUM_W-1:0], m_tdata[2*SUM_W-1:SUM_W]);
                end
                else
                begin
                    want = window_q.pop_front();
                    if (m_tdata[SUM_W-1:0] !== want.window_sum)
                    begin
                        fail_count++;
                        $display("%0t: window_sum mismatch expected %h actual %h",
                                 $time, want.window_sum, m_tdata[SUM_W-1:0]);
                    end
                    if (m_tdata[2*SUM_W-1:SUM_W] !== want.scaled_mean)
                    begin
                        fail_count++;
                        $display("%0t: scaled_mean mismatch expected %h actual %h",
                                 $time, want.scaled_mean, m_tdata[2*SUM_W-1:SUM_W]);
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_INTEGER_RATIO:
                    begin
                        ratio_reg = cfg_wdata;
                        restart_window();
                    end
                    CFG_FRAC_NUMERATOR:
                    begin
                        num_reg = cfg_wdata;
                        restart_window();
                    end
                    CFG_FRAC_DENOMINATOR:
                    begin
                        den_reg = cfg_wdata;
                        restart_window();
                    end
                    default:
                    begin
                        // unmapped index: no register, no restart
                    end
                endcase
            end

            if (s_tvalid && s_tready)
                take_sample(s_tdata);

            pending = window_q.size();
        end
    end

endmodule

// File: test/rational_boxcar_decimator_top_tb.sv
// Testbench top for the rational boxcar decimator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module rational_boxcar_decimator_top_tb
    import rbd_pkg::*;
();

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 200;
    localparam int LONG_HOLD     = 600;
    localparam int RANDOM_ITEMS  = 850;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = 2'd3;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [SAMPLE_FIELD_W-1:0] s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [2*SUM_W-1:0]        m_tdata;
    logic                      cfg_we;
    logic [CFG_ADDR_W-1:0]     cfg_addr;
    logic [CFG_W-1:0]          cfg_wdata;

    int fail_count;
    int pending;
    int windows_seen;
    int samples_sent;
    int settings_used;
    bit no_idle;
    bit long_hold_req;

    rational_boxcar_decimator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    rbd_window_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .windows_seen (windows_seen)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length: mostly none or short, occasionally long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic logic [SAMPLE_FIELD_W-1:0] pick_sample();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return '0;
        else if (k == 1)
            return '1;
        else
            return SAMPLE_FIELD_W'($urandom);
    endfunction

    // One sample transaction, with an optional gap in front
    task automatic send_sample(input logic [SAMPLE_FIELD_W-1:0] value);
        int unsigned gap;
        gap = no_idle ? 0 : idle_len();
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = value;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        samples_sent++;
    endtask

    // Wait until every predicted window has come out and the block is quiet
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_addr  = idx;
        cfg_wdata = val;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic set_ratio(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] n,
                             input logic [CFG_W-1:0] d);
        drain();
        write_reg(CFG_INTEGER_RATIO, r);
        write_reg(CFG_FRAC_NUMERATOR, n);
        write_reg(CFG_FRAC_DENOMINATOR, d);
        settings_used++;
    endtask

    // Receiver: random stalls, free-running stretches, and one long hold
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else if (no_idle)
                m_tready = 1'b1;
            else if (stall_left != 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d windows outstanding", CYCLE_LIMIT, pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        logic [CFG_W-1:0] r;
        logic [CFG_W-1:0] n;
        logic [CFG_W-1:0] d;
        int unsigned      kind;
        int unsigned      count;
        int unsigned      pause_at;

        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_we        = 1'b0;
        cfg_addr      = CFG_INTEGER_RATIO;
        cfg_wdata     = '0;
        no_idle       = 1'b0;
        long_hold_req = 1'b0;
        samples_sent  = 0;
        settings_used = 1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Reset ratio 1: every sample is a window; field extremes and bit patterns
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'hAAAA);
        send_sample(16'h5555);
        send_sample(16'h8000);

        // Ratio 3.5: a full-scale split boundary sample; a zero sample closes the next window
        set_ratio(16'd3, 16'd1, 16'd2);
        repeat (6) send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h1234);

        // Zero ratio and zero denominator both act as one
        set_ratio(16'd0, 16'd0, 16'd0);
        send_sample(16'hFFFF);
        send_sample(16'h0001);

        // Numerator above the denominator is clamped to D-1
        set_ratio(16'd2, 16'd9, 16'd4);
        repeat (4) send_sample(16'hFFFF);

        // Largest denominator and numerator just below it; unmapped index write
        set_ratio(16'd1, 16'd65534, 16'd65535);
        drain();
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        repeat (4) send_sample(16'hFFFF);

        // Largest ratio: no window closes within a few samples
        set_ratio(16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (2) send_sample(16'hFFFF);

        // Output held off for a long stretch while samples keep coming
        set_ratio(16'd1, 16'd0, 16'd1);
        long_hold_req = 1'b1;
        repeat (30) send_sample(pick_sample());
        while (long_hold_req) @(negedge clk);

        // Random settings, each followed by a run of random samples
        while (samples_sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 11);
            case (kind)
                0:
                begin
                    r = 16'hFFFF;
                    n = CFG_W'($urandom);
                    d = CFG_W'($urandom);
                end
                1:
                begin
                    r = CFG_W'($urandom);
                    n = CFG_W'($urandom);
                    d = CFG_W'($urandom);
                end
                2:
                begin
                    r = '0;
                    d = CFG_W'($urandom_range(0, 9));
                    n = CFG_W'($urandom_range(0, 9));
                end
                default:
                begin
                    r = CFG_W'($urandom_range(1, 6));
                    if ($urandom_range(0, 2) == 0)
                        d = CFG_W'($urandom);
                    else
                        d = CFG_W'($urandom_range(1, 12));
                    if ($urandom_range(0, 4) == 0)
                        n = d + CFG_W'($urandom_range(0, 2));
                    else if (d == '0)
                        n = '0;
                    else
                        n = CFG_W'($urandom_range(0, int'(d) - 1));
                end
            endcase
            set_ratio(r, n, d);
            no_idle  = ($urandom_range(0, 3) == 0);
            count    = (kind <= 1) ? 10 : $urandom_range(20, 70);
            pause_at = $urandom_range(0, count - 1);
            for (int unsigned i = 0; i < count; i++)
            begin
                // at one random point the sender waits for every expected window before going on
                if (i == pause_at)
                begin
                    s_tvalid = 1'b0;
                    while (pending != 0) @(negedge clk);
                end
                send_sample(pick_sample());
            end
            no_idle = 1'b0;
        end

        drain();
        $display("covered %0d samples over %0d ratio settings, %0d windows compared,",
                 samples_sent, settings_used, windows_seen);
        $display("including zero and clamped settings, split boundaries and a long output stall");
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
